>>> design/sparse_set_handle_pool_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handle pool
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_HANDLE_POOL_TOP_MACROS_SVH
`define SPARSE_SET_HANDLE_POOL_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent, or later with a delay.
`define SSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths, codes and controller/datapath command type of the handle pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssp_pkg;

  // Default sizing
  localparam int HANDLES_DEF    = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Transaction field widths
  localparam int ACTION_W = 3;
  localparam int HANDLE_W = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Per-cycle commands from the controller to the datapath
  typedef struct packed {
    logic lookup;  // accept: latch inputs, read map and free-stack top
    logic fetch;   // read data word and last dense entry
    logic exec;    // update stores and register the result
  } ssp_cmd_t;

endpackage

>>> design/ssp_ctrl.sv
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer of the handle pool: accept, fetch and execute phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  output ssp_pkg::ssp_cmd_t cmd_o
);
  import ssp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start && !busy_q;

  // Commands for the current cycle
  always_comb begin
    cmd_o.lookup = accept;
    cmd_o.fetch  = (state_q == S_FETCH);
    cmd_o.exec   = (state_q == S_EXEC);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_FETCH;
            busy_q  <= 1'b1;
          end
        end
        S_FETCH: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

>>> design/ssp_datapath.sv
// ----------------------------------------------------------------------------
// ssp_datapath
// Map, dense arrays, free stack, counters and result registers of the pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssp_datapath #(
  parameter int HANDLES    = ssp_pkg::HANDLES_DEF,
  parameter int DATA_WIDTH = ssp_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssp_pkg::ssp_cmd_t             cmd_i,
  input  logic [ssp_pkg::ACTION_W-1:0]  action_i,
  input  logic [ssp_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [ssp_pkg::VALUE_W-1:0]   value_i,
  output logic [ssp_pkg::STATUS_W-1:0]  status_o,
  output logic [ssp_pkg::HANDLE_W-1:0]  new_handle_o,
  output logic                          present_o,
  output logic [ssp_pkg::VALUE_W-1:0]   data_out_o,
  output logic [ssp_pkg::SLOT_W-1:0]    slot_o,
  output logic [ssp_pkg::COUNT_W-1:0]   live_count_o
);
  import ssp_pkg::*;

  localparam int IW = $clog2(HANDLES);
  localparam int CW = $clog2(HANDLES + 1);

  // Stores
  logic [IW-1:0]         h2s_mem  [HANDLES];
  logic [IW-1:0]         s2h_mem  [HANDLES];
  logic [DATA_WIDTH-1:0] data_mem [HANDLES];
  logic [IW-1:0]         free_mem [HANDLES];

  // Control state
  logic [HANDLES-1:0] valid_q, valid_d;
  logic [CW-1:0]      entry_cnt_q, entry_cnt_d;
  logic [CW-1:0]      free_depth_q, free_depth_d;
  logic [CW-1:0]      fresh_q, fresh_d;

  // Latched transaction
  logic [ACTION_W-1:0] action_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [VALUE_W-1:0]  value_q;

  // Registered read data
  logic [IW-1:0]         h2s_rd_q;
  logic [IW-1:0]         free_rd_q;
  logic [IW-1:0]         moved_q;
  logic [DATA_WIDTH-1:0] data_rd_q;

  // Result registers
  logic [STATUS_W-1:0] status_q, status_d;
  logic [HANDLE_W-1:0] new_handle_q, new_handle_d;
  logic                present_q, present_d;
  logic [VALUE_W-1:0]  data_out_q, data_out_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [COUNT_W-1:0]  live_q, live_d;

  // Write ports
  logic                  h2s_we,  s2h_we,  data_we,  free_we;
  logic [IW-1:0]         h2s_wa,  s2h_wa,  data_wa,  free_wa;
  logic [IW-1:0]         h2s_wd,  s2h_wd,  free_wd;
  logic [DATA_WIDTH-1:0] data_wd;

  // Decoded values
  logic [IW-1:0]         h_idx;
  logic                  h_in_range;
  logic                  live;
  logic [IW-1:0]         last;
  logic [IW-1:0]         data_ra;
  logic                  use_free;
  logic [IW-1:0]         got;
  logic                  can_create;
  logic [DATA_WIDTH-1:0] wr_word;

  assign h_idx      = IW'(handle_q);
  assign h_in_range = int'(handle_q) < HANDLES;
  assign live       = h_in_range && valid_q[h_idx];
  assign last       = IW'(entry_cnt_q - 1'b1);
  assign data_ra    = (action_q == ACT_REMOVE) ? last : h2s_rd_q;
  assign use_free   = (free_depth_q != '0);
  assign got        = use_free ? free_rd_q : IW'(fresh_q);
  assign can_create = (use_free || (fresh_q < CW'(HANDLES))) &&
                      (entry_cnt_q < CW'(HANDLES));
  assign wr_word    = DATA_WIDTH'(value_q);

  // Execute phase: store updates and result
  always_comb begin
    valid_d      = valid_q;
    entry_cnt_d  = entry_cnt_q;
    free_depth_d = free_depth_q;
    fresh_d      = fresh_q;
    h2s_we = 1'b0; h2s_wa = '0; h2s_wd = '0;
    s2h_we = 1'b0; s2h_wa = '0; s2h_wd = '0;
    data_we = 1'b0; data_wa = '0; data_wd = '0;
    free_we = 1'b0; free_wa = '0; free_wd = '0;
    status_d     = ST_OK;
    new_handle_d = '0;
    present_d    = 1'b0;
    data_out_d   = '0;
    slot_d       = '0;

    if (cmd_i.exec) begin
      case (action_q)
        ACT_CREATE: begin
          if (can_create) begin
            s2h_we  = 1'b1; s2h_wa  = IW'(entry_cnt_q); s2h_wd = got;
            h2s_we  = 1'b1; h2s_wa  = got;              h2s_wd = IW'(entry_cnt_q);
            data_we = 1'b1; data_wa = IW'(entry_cnt_q); data_wd = '0;
            valid_d[got] = 1'b1;
            entry_cnt_d  = entry_cnt_q + 1'b1;
            if (use_free) begin
              free_depth_d = free_depth_q - 1'b1;
            end else begin
              fresh_d = fresh_q + 1'b1;
            end
            new_handle_d = HANDLE_W'(got);
            slot_d       = SLOT_W'(entry_cnt_q);
          end else begin
            status_d = ST_FULL;
          end
        end
        ACT_REMOVE: begin
          if (live) begin
            // Move the last dense entry into the vacated slot
            if (h2s_rd_q != last) begin
              s2h_we  = 1'b1; s2h_wa  = h2s_rd_q; s2h_wd  = moved_q;
              data_we = 1'b1; data_wa = h2s_rd_q; data_wd = data_rd_q;
              h2s_we  = 1'b1; h2s_wa  = moved_q;  h2s_wd  = h2s_rd_q;
            end
            valid_d[h_idx] = 1'b0;
            entry_cnt_d    = entry_cnt_q - 1'b1;
            if (free_depth_q < CW'(HANDLES)) begin
              free_we = 1'b1; free_wa = IW'(free_depth_q); free_wd = h_idx;
              free_depth_d = free_depth_q + 1'b1;
            end
          end else begin
            status_d = ST_ABSENT;
          end
        end
        ACT_QUERY: begin
          if (live) begin
            present_d  = 1'b1;
            slot_d     = SLOT_W'(h2s_rd_q);
            data_out_d = VALUE_W'(data_rd_q);
          end else begin
            status_d = ST_ABSENT;
          end
        end
        ACT_WRITE: begin
          if (live) begin
            data_we = 1'b1; data_wa = h2s_rd_q; data_wd = wr_word;
            present_d  = 1'b1;
            slot_d     = SLOT_W'(h2s_rd_q);
            data_out_d = VALUE_W'(wr_word);
          end else begin
            status_d = ST_ABSENT;
          end
        end
        ACT_CLEAR: begin
          valid_d      = '0;
          entry_cnt_d  = '0;
          free_depth_d = '0;
          fresh_d      = '0;
        end
        default: begin
        end
      endcase
    end
    live_d = COUNT_W'(entry_cnt_d);
  end

  // Control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      entry_cnt_q  <= '0;
      free_depth_q <= '0;
      fresh_q      <= '0;
    end else begin
      valid_q      <= valid_d;
      entry_cnt_q  <= entry_cnt_d;
      free_depth_q <= free_depth_d;
      fresh_q      <= fresh_d;
    end
  end

  // Transaction latch and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      action_q <= action_i;
      handle_q <= handle_i;
      value_q  <= value_i;
    end
    if (cmd_i.exec) begin
      status_q     <= status_d;
      new_handle_q <= new_handle_d;
      present_q    <= present_d;
      data_out_q   <= data_out_d;
      slot_q       <= slot_d;
      live_q       <= live_d;
    end
  end

  // Handle-to-slot map
  always_ff @(posedge clk_i) begin
    if (h2s_we) begin
      h2s_mem[h2s_wa] <= h2s_wd;
    end
    if (cmd_i.lookup) begin
      h2s_rd_q <= h2s_mem[IW'(handle_i)];
    end
  end

  // Free stack, top read at accept
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    if (cmd_i.lookup) begin
      free_rd_q <= free_mem[IW'(free_depth_q - 1'b1)];
    end
  end

  // Slot-to-handle array, last entry read in fetch
  always_ff @(posedge clk_i) begin
    if (s2h_we) begin
      s2h_mem[s2h_wa] <= s2h_wd;
    end
    if (cmd_i.fetch) begin
      moved_q <= s2h_mem[last];
    end
  end

  // Dense data words
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_wa] <= data_wd;
    end
    if (cmd_i.fetch) begin
      data_rd_q <= data_mem[data_ra];
    end
  end

  assign status_o     = status_q;
  assign new_handle_o = new_handle_q;
  assign present_o    = present_q;
  assign data_out_o   = data_out_q;
  assign slot_o       = slot_q;
  assign live_count_o = live_q;

endmodule

>>> design/sparse_set_handle_pool_top.sv
// ----------------------------------------------------------------------------
// sparse_set_handle_pool_top
// Fixed-size sparse set handing out handles, with a LIFO free list.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction (action_i, handle_i, value_i) is taken at a
//   rising edge with start high and busy low. busy then stays high while the
//   transaction runs through the fetch and execute states.
//   Result channel: done_o is high for exactly one cycle with the result on
//   status_o, new_handle_o, present_o, data_out_o, slot_o and live_count_o.
//   The receiver cannot stall; results must be taken when shown.
//   done_o is registered and rises once the execute state ends. The block
//   takes no new transaction until the last is done; the chain of registered
//   reads runs map and free-stack top, then data word and last dense entry,
//   then the update of all stores.
//   A new transaction may be started in the cycle that shows done_o.
//   Reset: the pool is empty at once (live bits, counters and free depth
//   cleared by reset); no clearing pass runs, so the block is ready
//   immediately after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_set_handle_pool_top_macros.svh"

module sparse_set_handle_pool_top #(
  parameter int HANDLES    = ssp_pkg::HANDLES_DEF,
  parameter int DATA_WIDTH = ssp_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ssp_pkg::ACTION_W-1:0]  action_i,
  input  logic [ssp_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [ssp_pkg::VALUE_W-1:0]   value_i,
  output logic                          done_o,
  output logic [ssp_pkg::STATUS_W-1:0]  status_o,
  output logic [ssp_pkg::HANDLE_W-1:0]  new_handle_o,
  output logic                          present_o,
  output logic [ssp_pkg::VALUE_W-1:0]   data_out_o,
  output logic [ssp_pkg::SLOT_W-1:0]    slot_o,
  output logic [ssp_pkg::COUNT_W-1:0]   live_count_o
);
  import ssp_pkg::*;

  ssp_cmd_t cmd;

  // Sequencer
  ssp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Stores and result registers
  ssp_datapath #(
    .HANDLES    (HANDLES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .handle_i     (handle_i),
    .value_i      (value_i),
    .status_o     (status_o),
    .new_handle_o (new_handle_o),
    .present_o    (present_o),
    .data_out_o   (data_out_o),
    .slot_o       (slot_o),
    .live_count_o (live_count_o)
  );

  // Checks
  `SSP_ASSERT_IMP(a_done_latency, start && !busy, ##3 done_o, "result strobe missing")
  `SSP_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy && !done_o, "not busy after accept")
  `SSP_ASSERT_IMP(a_done_not_busy, done_o, !busy, "result shown while busy")
  `SSP_ASSERT_IMP(a_status_code, done_o, (status_o == ST_OK || status_o == ST_ABSENT || status_o == ST_FULL), "bad status code")

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse-set handle pool. Directed sequences
// cover the basic operations, the swap-with-last on remove, free-list reuse,
// clear and the pool-full case; random fill/drain traffic with idle bursts
// follows. A scoreboard predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ssp_pkg::*;

  localparam int POOL_HANDLES = HANDLES_DEF;

  // Action codes the block does not define; they must leave the pool alone
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] new_handle;
    logic                present;
    logic [VALUE_W-1:0]  data;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  live_count;
  } pool_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] action_i;
  logic [HANDLE_W-1:0] handle_i;
  logic [VALUE_W-1:0]  value_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [HANDLE_W-1:0] new_handle_o;
  logic                present_o;
  logic [VALUE_W-1:0]  data_out_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [COUNT_W-1:0]  live_count_o;

  sparse_set_handle_pool_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .handle_i     (handle_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .new_handle_o (new_handle_o),
    .present_o    (present_o),
    .data_out_o   (data_out_o),
    .slot_o       (slot_o),
    .live_count_o (live_count_o)
  );

  // Shadow copy of the pool
  logic [SLOT_W-1:0]   map_slot     [POOL_HANDLES];
  bit   [POOL_HANDLES-1:0] live_bits;
  logic [HANDLE_W-1:0] dense_handle [POOL_HANDLES];
  logic [VALUE_W-1:0]  dense_data   [POOL_HANDLES];
  logic [HANDLE_W-1:0] free_lifo    [POOL_HANDLES];
  int free_top;
  int fresh_next;
  int live_total;

  pool_result_t pool_expect_q[$];

  // Run statistics
  int n_sent, n_results, n_bad;
  int n_full, n_absent, n_moves, n_clears, n_reuse, peak_live;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Global time limit
  initial begin
    #3_000_000;
    $display("sparse_set_handle_pool_top regression: fail");
    $finish;
  end

  function automatic void clear_pool_model();
    live_bits  = '0;
    free_top   = 0;
    fresh_next = 0;
    live_total = 0;
  endfunction

  // Advance the shadow pool by one transaction and return its result
  function automatic pool_result_t predict_pool(input logic [ACTION_W-1:0] act,
                                                input logic [HANDLE_W-1:0] hdl,
                                                input logic [VALUE_W-1:0]  val);
    pool_result_t res;
    int got, idx, last;
    logic [HANDLE_W-1:0] moved;
    res = '0;
    case (act)
      ACT_CREATE: begin
        got = -1;
        if (free_top > 0) begin
          free_top--;
          got = int'(free_lifo[free_top]);
          n_reuse++;
        end else if (fresh_next < POOL_HANDLES) begin
          got = fresh_next;
          fresh_next++;
        end
        if (got >= 0 && live_total < POOL_HANDLES) begin
          idx = live_total;
          live_total++;
          dense_handle[idx] = got[HANDLE_W-1:0];
          map_slot[got]     = idx[SLOT_W-1:0];
          live_bits[got]    = 1'b1;
          dense_data[idx]   = '0;
          res.new_handle    = got[HANDLE_W-1:0];
          res.slot          = idx[SLOT_W-1:0];
        end else begin
          res.status = ST_FULL;
          n_full++;
        end
      end
      ACT_REMOVE: begin
        if (!live_bits[hdl]) begin
          res.status = ST_ABSENT;
          n_absent++;
        end else begin
          idx  = int'(map_slot[hdl]);
          last = live_total - 1;
          // last dense entry fills the hole
          if (idx != last) begin
            moved             = dense_handle[last];
            dense_handle[idx] = moved;
            dense_data[idx]   = dense_data[last];
            map_slot[moved]   = idx[SLOT_W-1:0];
            n_moves++;
          end
          live_bits[hdl] = 1'b0;
          live_total--;
          if (free_top < POOL_HANDLES) begin
            free_lifo[free_top] = hdl;
            free_top++;
          end
        end
      end
      ACT_QUERY, ACT_WRITE: begin
        if (!live_bits[hdl]) begin
          res.status = ST_ABSENT;
          n_absent++;
        end else begin
          idx = int'(map_slot[hdl]);
          if (act == ACT_WRITE) dense_data[idx] = val;
          res.present = 1'b1;
          res.slot    = idx[SLOT_W-1:0];
          res.data    = dense_data[idx];
        end
      end
      ACT_CLEAR: begin
        clear_pool_model();
        n_clears++;
      end
      default: ;
    endcase
    if (live_total > peak_live) peak_live = live_total;
    res.live_count = live_total[COUNT_W-1:0];
    return res;
  endfunction

  // Random live handle, or any handle when the pool is empty
  function automatic logic [HANDLE_W-1:0] pick_live_handle();
    logic [HANDLE_W-1:0] live_q[$];
    for (int h = 0; h < POOL_HANDLES; h++) begin
      if (live_bits[h]) live_q.push_back(h[HANDLE_W-1:0]);
    end
    if (live_q.size() == 0) return HANDLE_W'($urandom_range(0, POOL_HANDLES - 1));
    return live_q[$urandom_range(0, live_q.size() - 1)];
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Send one transaction; start is left high so the next one can follow
  task automatic send_op(input logic [ACTION_W-1:0] act,
                         input logic [HANDLE_W-1:0] hdl,
                         input logic [VALUE_W-1:0]  val);
    @(negedge clk_i);
    start    = 1'b1;
    action_i = act;
    handle_i = hdl;
    value_i  = val;
    do @(posedge clk_i); while (busy);
    pool_expect_q.push_back(predict_pool(act, hdl, val));
    n_sent++;
  endtask

  // Hold start low with junk on the command fields
  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start    = 1'b0;
      action_i = ACTION_W'($urandom);
      handle_i = HANDLE_W'($urandom);
      value_i  = $urandom;
    end
  endtask

  // Result checker: the block cannot be stalled, so every done is taken
  always @(posedge clk_i) begin
    pool_result_t got_res, exp_res;
    if (rst_ni && done_o) begin
      got_res = '{status_o, new_handle_o, present_o, data_out_o, slot_o, live_count_o};
      n_results++;
      if (pool_expect_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("ERROR: result with nothing pending: st=%0d nh=%0d pr=%0d data=%h slot=%0d cnt=%0d",
                   got_res.status, got_res.new_handle, got_res.present, got_res.data,
                   got_res.slot, got_res.live_count);
      end else begin
        exp_res = pool_expect_q.pop_front();
        if (got_res !== exp_res) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"ERROR: result %0d: expected st=%0d nh=%0d pr=%0d data=%h slot=%0d cnt=%0d,",
                      " got st=%0d nh=%0d pr=%0d data=%h slot=%0d cnt=%0d"},
                     n_results, exp_res.status, exp_res.new_handle, exp_res.present,
                     exp_res.data, exp_res.slot, exp_res.live_count, got_res.status,
                     got_res.new_handle, got_res.present, got_res.data, got_res.slot,
                     got_res.live_count);
        end
      end
    end
  end

  // Basic operations, swap on remove, reuse, spare codes and clear
  task automatic test_basic_ops();
    send_op(ACT_QUERY, 6'd0, '0);              // absent on an empty pool
    send_op(ACT_REMOVE, 6'd63, '1);
    send_op(ACT_WRITE, 6'd63, '1);
    send_op(ACT_CREATE, 6'd0, '0);             // fresh handle 0
    send_op(ACT_CREATE, 6'd63, '1);
    send_op(ACT_CREATE, 6'd21, 32'h5555_5555);
    send_op(ACT_WRITE, 6'd0, '1);
    send_op(ACT_WRITE, 6'd2, 32'hA5A5_5A5A);
    send_op(ACT_QUERY, 6'd0, '0);
    send_op(ACT_REMOVE, 6'd0, '0);             // handle 2 moves into slot 0
    send_op(ACT_QUERY, 6'd2, '0);
    send_op(ACT_REMOVE, 6'd1, '0);             // last slot, no move
    send_op(ACT_CREATE, 6'd42, 32'hAAAA_AAAA); // reuses 1, then 0
    send_op(ACT_CREATE, 6'd0, '0);
    send_op(ACT_CREATE, 6'd0, '0);             // fresh again
    send_op(ACT_QUERY, 6'd1, '0);              // data zeroed by create
    send_op(ACT_WRITE, 6'd3, 32'h0000_0001);
    send_op(ACT_SPARE_A, 6'd3, '1);
    send_op(ACT_SPARE_B, 6'd63, 32'h8000_0000);
    send_op(ACT_SPARE_C, 6'd0, '0);
    send_op(ACT_CLEAR, 6'd42, '1);
    send_op(ACT_QUERY, 6'd3, '0);
    send_op(ACT_CREATE, 6'd0, '0);             // counter restarts at 0
    send_op(ACT_WRITE, 6'd0, 32'h5A5A_A5A5);
    send_op(ACT_QUERY, 6'd0, '0);
  endtask

  // Fill every handle, hit full, then free and refill one
  task automatic test_pool_full();
    send_op(ACT_CLEAR, '0, '0);
    for (int i = 0; i < POOL_HANDLES; i++) send_op(ACT_CREATE, '0, '0);
    send_op(ACT_CREATE, '0, '0);
    send_op(ACT_WRITE, 6'd63, '1);
    send_op(ACT_REMOVE, 6'd10, '0);
    send_op(ACT_QUERY, 6'd63, '0);
    send_op(ACT_CREATE, '0, '0);
    send_op(ACT_CREATE, '0, '0);
    send_op(ACT_REMOVE, 6'd63, '0);
    send_op(ACT_REMOVE, 6'd63, '0);
  endtask

  // Random traffic alternating between filling and draining the pool
  task automatic test_random_traffic(input int n_items, input int n_quiet);
    bit filling;
    int r;
    logic [ACTION_W-1:0] act;
    logic [HANDLE_W-1:0] hdl;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i < n_items - n_quiet && $urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 14));
      r   = $urandom_range(0, 99);
      hdl = pick_live_handle();
      act = ACT_QUERY;
      if (filling) begin
        if (r < 65)      act = ACT_CREATE;
        else if (r < 75) act = ACT_REMOVE;
        else if (r < 85) act = ACT_QUERY;
        else if (r < 95) act = ACT_WRITE;
      end else begin
        if (r < 10)      act = ACT_CREATE;
        else if (r < 65) act = ACT_REMOVE;
        else if (r < 77) act = ACT_QUERY;
        else if (r < 89) act = ACT_WRITE;
        else if (r < 91) act = ACT_CLEAR;
      end
      // noise: any handle, spare codes
      if ((filling && r >= 95) || (!filling && r >= 91)) begin
        hdl = HANDLE_W'($urandom_range(0, POOL_HANDLES - 1));
        case ($urandom_range(0, 5))
          0:       act = ACT_REMOVE;
          1:       act = ACT_QUERY;
          2:       act = ACT_WRITE;
          3:       act = ACT_SPARE_A;
          4:       act = ACT_SPARE_B;
          default: act = ACT_SPARE_C;
        endcase
      end
      if (act == ACT_CREATE || act == ACT_CLEAR) hdl = HANDLE_W'($urandom);
      send_op(act, hdl, pick_word());
      if (filling && live_total == POOL_HANDLES && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (!filling && live_total == 0) filling = 1'b1;
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    action_i = ACT_QUERY;
    handle_i = '0;
    value_i  = '0;
    n_sent = 0; n_results = 0; n_bad = 0;
    n_full = 0; n_absent = 0; n_moves = 0; n_clears = 0; n_reuse = 0; peak_live = 0;
    clear_pool_model();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_pool_full();
    test_random_traffic(450, 100);

    @(negedge clk_i);
    start = 1'b0;
    while (pool_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d transactions, %0d results checked, peak %0d live handles.",
             n_sent, n_results, peak_live);
    $display("Pool full %0d, absent handle %0d, swaps on remove %0d, reuses %0d, clears %0d.",
             n_full, n_absent, n_moves, n_reuse, n_clears);
    if (n_bad == 0) begin
      $display("sparse_set_handle_pool_top regression: pass");
    end else begin
      $display("%0d mismatching results", n_bad);
      $display("sparse_set_handle_pool_top regression: fail");
    end
    $finish;
  end

endmodule
